[rtl/lss_pkg.sv]
// shared types and constants of the streaming laplacian stencil
`timescale 1ns / 1ps

package lss_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_STENCIL_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_SCALE   = 2'd1;

   // stencil mode codes
   localparam logic MODE_THREE_POINT = 1'b0;
   localparam logic MODE_FIVE_POINT  = 1'b1;

   localparam int SCALE_W = 32;
   localparam int RATE_W  = 48;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd256;

   // markers that travel with every result
   typedef struct packed {
      logic last_result;
      logic short_row;
   } rsp_flags_type;

endpackage

[rtl/lss_stencil.sv]
// sample window, row counter and weighted-sum queue of the stencil
`timescale 1ns / 1ps

module lss_stencil #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int SUM_W = SAMPLE_WIDTH + 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stencil_mode_i,
   input  logic                        req_valid_i,
   output logic                        req_ready_o,
   input  logic [SAMPLE_WIDTH-1:0]     sample_i,
   input  logic                        last_sample_i,
   output logic                        sum_valid_o,
   input  logic                        sum_ready_i,
   output logic signed [SUM_W-1:0]     sum_o,
   output lss_pkg::rsp_flags_type      flags_o
);
   import lss_pkg::*;

   localparam int EXT_W = SUM_W - SAMPLE_WIDTH;
   localparam logic signed [SUM_W-1:0] K2  = SUM_W'(2);
   localparam logic signed [SUM_W-1:0] K3  = SUM_W'(3);
   localparam logic signed [SUM_W-1:0] K16 = SUM_W'(16);
   localparam logic signed [SUM_W-1:0] K17 = SUM_W'(17);
   localparam logic signed [SUM_W-1:0] K30 = SUM_W'(30);
   localparam logic signed [SUM_W-1:0] K46 = SUM_W'(46);

   logic [SAMPLE_WIDTH-1:0] window_ff [4];
   logic [SAMPLE_WIDTH-1:0] window_in [4];
   logic [2:0]              count_ff, count_in;

   logic signed [SUM_W-1:0] q_sum_ff [3];
   logic signed [SUM_W-1:0] q_sum_in [3];
   rsp_flags_type           q_flags_ff [3];
   rsp_flags_type           q_flags_in [3];
   logic [1:0]              q_cnt_ff, q_cnt_in;

   logic signed [SUM_W-1:0] w [4];
   logic signed [SUM_W-1:0] c;
   logic [2:0]              n;
   logic                    accept, pop;
   logic signed [SUM_W-1:0] new_sum [3];
   rsp_flags_type           new_flags [3];
   logic [1:0]              new_cnt;
   logic                    has_body;

   for (genvar i = 0; i < 4; i++) begin : g_ext
      assign w[i] = {{EXT_W{window_ff[i][SAMPLE_WIDTH-1]}}, window_ff[i]};
   end
   assign c = {{EXT_W{sample_i[SAMPLE_WIDTH-1]}}, sample_i};

   // samples seen in the row including this one, held at seven
   assign n = (count_ff == 3'd7) ? 3'd7 : count_ff + 3'd1;

   assign sum_valid_o = (q_cnt_ff != 2'd0);
   assign pop         = sum_valid_o && sum_ready_i;
   assign req_ready_o = (q_cnt_ff == 2'd0) || ((q_cnt_ff == 2'd1) && pop);
   assign accept      = req_valid_i && req_ready_o;
   assign sum_o       = q_sum_ff[0];
   assign flags_o     = q_flags_ff[0];

   // results caused by the incoming sample, in output order
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         new_sum[i]   = '0;
         new_flags[i] = '0;
      end
      new_cnt  = 2'd0;
      has_body = 1'b0;
      unique case (stencil_mode_i)
         MODE_THREE_POINT: begin
            has_body   = (n >= 3'd2);
            new_sum[0] = (n == 3'd2) ? (c - K3 * w[0]) : (w[1] - K2 * w[0] + c);
            new_sum[1] = w[0] - K3 * c;
            new_flags[1].last_result = 1'b1;
            if (has_body) begin
               new_cnt = last_sample_i ? 2'd2 : 2'd1;
            end
         end
         MODE_FIVE_POINT: begin
            // a row end needs four samples, a row body three
            has_body = (n >= (last_sample_i ? 3'd4 : 3'd3));
            if (n == 3'd3) begin
               new_sum[0] = K17 * w[0] - K46 * w[1] - c;
            end else if (n == 3'd4) begin
               new_sum[0] = K17 * w[2] - K30 * w[1] + K16 * w[0] - c;
            end else begin
               new_sum[0] = K16 * w[2] - w[3] - K30 * w[1] + K16 * w[0] - c;
            end
            new_sum[1] = K16 * w[1] - w[2] - K30 * w[0] + K17 * c;
            new_sum[2] = K17 * w[0] - w[1] - K46 * c;
            new_flags[2].last_result = 1'b1;
            if (has_body) begin
               new_cnt = last_sample_i ? 2'd3 : 2'd1;
            end
         end
         default: begin
         end
      endcase
      // row ends before the stencil fits
      if (last_sample_i && !has_body) begin
         new_sum[0]   = '0;
         new_flags[0] = '{last_result: 1'b1, short_row: 1'b1};
         new_cnt      = 2'd1;
      end
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      q_sum_in   = q_sum_ff;
      q_flags_in = q_flags_ff;
      q_cnt_in   = q_cnt_ff;
      if (accept) begin
         if (last_sample_i) begin
            for (int i = 0; i < 4; i++) begin
               window_in[i] = '0;
            end
            count_in = 3'd0;
         end else begin
            window_in[3] = window_ff[2];
            window_in[2] = window_ff[1];
            window_in[1] = window_ff[0];
            window_in[0] = sample_i;
            count_in     = n;
         end
         // queue is empty or drains its only entry in this cycle
         q_sum_in   = new_sum;
         q_flags_in = new_flags;
         q_cnt_in   = new_cnt;
      end else if (pop) begin
         q_sum_in[0]   = q_sum_ff[1];
         q_sum_in[1]   = q_sum_ff[2];
         q_flags_in[0] = q_flags_ff[1];
         q_flags_in[1] = q_flags_ff[2];
         q_cnt_in      = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            window_ff[i] <= '0;
         end
         count_ff <= 3'd0;
         q_cnt_ff <= 2'd0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_sum_ff   <= q_sum_in;
      q_flags_ff <= q_flags_in;
   end

endmodule

[rtl/lss_scale.sv]
// grid-scale multiply, round half up and saturation with the result register
`timescale 1ns / 1ps

module lss_scale #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int SUM_W = SAMPLE_WIDTH + 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lss_pkg::SCALE_W-1:0]     grid_scale_i,
   input  logic                            sum_valid_i,
   output logic                            sum_ready_o,
   input  logic signed [SUM_W-1:0]         sum_i,
   input  lss_pkg::rsp_flags_type          flags_i,
   output logic                            rsp_valid_o,
   input  logic                            rsp_ready_i,
   output logic [lss_pkg::RATE_W-1:0]      rate_o,
   output lss_pkg::rsp_flags_type          flags_o
);
   import lss_pkg::*;

   localparam int PROD_W  = SUM_W + SCALE_W + 1;
   localparam int SHIFT   = SAMPLE_WIDTH - 10;
   localparam int SHIFT_W = PROD_W - SHIFT;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS =
      {{(PROD_W - SHIFT){1'b0}}, 1'b1, {(SHIFT - 1){1'b0}}};
   localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W - 1){1'b1}}};
   localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W - 1){1'b0}}};

   logic                     mul_vld_ff, mul_vld_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_flags_type            mul_flags_ff;
   logic                     out_vld_ff, out_vld_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   rsp_flags_type            out_flags_ff;

   logic                     out_adv, mul_load, out_load;
   logic signed [PROD_W-1:0] sum_ext, scale_ext, rounded;
   logic [SHIFT_W-1:0]       shifted;
   logic [SHIFT_W-RATE_W:0]  top_bits;

   assign out_adv     = !out_vld_ff || rsp_ready_i;
   assign sum_ready_o = !mul_vld_ff || out_adv;
   assign mul_load    = sum_valid_i && sum_ready_o;
   assign out_load    = mul_vld_ff && out_adv;

   // signed sum times unsigned scale
   assign sum_ext   = {{(PROD_W - SUM_W){sum_i[SUM_W-1]}}, sum_i};
   assign scale_ext = {{(PROD_W - SCALE_W){1'b0}}, grid_scale_i};
   assign prod_in   = sum_ext * scale_ext;

   assign mul_vld_in = sum_ready_o ? sum_valid_i : mul_vld_ff;
   assign out_vld_in = out_adv ? mul_vld_ff : out_vld_ff;

   // round half up, drop the fraction bits below q.16, clamp to 48 bits
   assign rounded  = prod_ff + ROUND_BIAS;
   assign shifted  = rounded[PROD_W-1:SHIFT];
   assign top_bits = shifted[SHIFT_W-1:RATE_W-1];

   always_comb begin
      if ((&top_bits) || !(|top_bits)) begin
         rate_in = shifted[RATE_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         rate_in = RATE_MIN;
      end else begin
         rate_in = RATE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff      <= prod_in;
         mul_flags_ff <= flags_i;
      end
      if (out_load) begin
         rate_ff      <= rate_in;
         out_flags_ff <= mul_flags_ff;
      end
   end

   assign rsp_valid_o = out_vld_ff;
   assign rate_o      = rate_ff;
   assign flags_o     = out_flags_ff;

endmodule

[rtl/laplacian_stencil_stream.sv]
// top level of the streaming one-dimensional finite-difference laplacian
`timescale 1ns / 1ps

// usage:
// - req_ channel carries one grid sample per transfer, tlast on the final
//   sample of a row; sample is two's complement with SAMPLE_WIDTH-2 fraction
//   bits in the low SAMPLE_WIDTH bits of req_tdata
// - rsp_ channel returns the scaled second difference per sample in order,
//   signed q31.16 rounded half up and saturated; tlast marks the final result
//   of a row and tuser flags a row too short for the selected stencil
// - csr_ channel writes stencil_mode (index 0) and grid_scale (index 1),
//   always ready; write only while no row result is still in flight
// - three-point mode lags one sample and five-point mode two, so the last
//   sample of a row produces two or three results
// - a sample is taken every cycle while rsp_tready does not stall and each
//   sample causes at most one result; a row end holds req_tready low while
//   the three-entry sum queue drains, one result per cycle when not stalled
// - the first result of a sample passes the sum queue, the multiply register
//   and the rounding result register before rsp, the rest follow
// - a stall on rsp_tready backs up through the result register, multiply
//   register and sum queue to req_tready; nothing is dropped
// - reset clears the window, row count and all valid flags and sets
//   stencil_mode to three-point and grid_scale to 1.0

module laplacian_stencil_stream #(
   parameter int SAMPLE_WIDTH = 32,
   localparam int REQ_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_DATA_W-1:0]            req_tdata,  // sample, zero padding
   input  logic                             req_tlast,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lss_pkg::RATE_W-1:0]       rsp_tdata,  // rate
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,  // short_row
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lss_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lss_pkg::SCALE_W-1:0]      csr_data
);
   import lss_pkg::*;

   localparam int SUM_W = SAMPLE_WIDTH + 7;

   logic                    stencil_mode_ff, stencil_mode_in;
   logic [SCALE_W-1:0]      grid_scale_ff, grid_scale_in;
   logic                    csr_write;

   logic                    sum_valid, sum_ready;
   logic signed [SUM_W-1:0] sum;
   rsp_flags_type           sum_flags, rsp_flags;

   // configuration registers, unknown indexes ignored
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      stencil_mode_in = stencil_mode_ff;
      grid_scale_in   = grid_scale_ff;
      if (csr_write) begin
         if (csr_index == REG_STENCIL_MODE) begin
            stencil_mode_in = csr_data[0];
         end else if (csr_index == REG_GRID_SCALE) begin
            grid_scale_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stencil_mode_ff <= MODE_THREE_POINT;
         grid_scale_ff   <= SCALE_RESET;
      end else begin
         stencil_mode_ff <= stencil_mode_in;
         grid_scale_ff   <= grid_scale_in;
      end
   end

   // window and weighted sums, up to three per row-ending sample
   lss_stencil #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_stencil (
      .clock          (clock),
      .reset          (reset),
      .stencil_mode_i (stencil_mode_ff),
      .req_valid_i    (req_tvalid),
      .req_ready_o    (req_tready),
      .sample_i       (req_tdata[SAMPLE_WIDTH-1:0]),
      .last_sample_i  (req_tlast),
      .sum_valid_o    (sum_valid),
      .sum_ready_i    (sum_ready),
      .sum_o          (sum),
      .flags_o        (sum_flags)
   );

   // scaling, rounding and the result register
   lss_scale #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .grid_scale_i (grid_scale_ff),
      .sum_valid_i  (sum_valid),
      .sum_ready_o  (sum_ready),
      .sum_i        (sum),
      .flags_i      (sum_flags),
      .rsp_valid_o  (rsp_tvalid),
      .rsp_ready_i  (rsp_tready),
      .rate_o       (rsp_tdata),
      .flags_o      (rsp_flags)
   );

   assign rsp_tlast = rsp_flags.last_result;
   assign rsp_tuser = rsp_flags.short_row;

endmodule

[bench/tb.sv]
// self-checking bench for the streaming laplacian stencil: directed rows, then random rows
`timescale 1ns / 1ps

module tb;
   import lss_pkg::*;

   localparam int SAMPLE_W = 32;
   localparam int CYCLE_LIMIT = 200000;
   // results pass the sum queue, multiply and result registers; this is a safe settle time
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_PERCENT = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 43;
   localparam int REPORT_LIMIT = 10;
   localparam longint RATE_HI = 64'sd140737488355327;
   localparam longint RATE_LO = -64'sd140737488355328;
   // register indexes the block has no register behind
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7fff_ffff;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
   localparam logic [SCALE_W-1:0] SCALE_MAX = 32'hffff_ffff;

   // one expected result of the stencil
   typedef struct packed {
      logic signed [RATE_W-1:0] rate;
      logic last_result;
      logic short_row;
   } rate_item_type;

   // tracks window, count and registers, and holds the rates still owed by the block
   class stencil_board;
      logic mode;
      logic [SCALE_W-1:0] scale;
      longint win[4];
      int unsigned count;
      rate_item_type owed_rates[$];
      int mismatches;

      function new();
         mode = MODE_THREE_POINT;
         scale = SCALE_RESET;
         foreach (win[i]) win[i] = 0;
         count = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [SCALE_W-1:0] data);
         if (idx == REG_STENCIL_MODE)
            mode = data[0];
         else if (idx == REG_GRID_SCALE)
            scale = data;
      endfunction

      // sum times scale, rounded half up to q.16 and clamped to 48 bits
      function logic signed [RATE_W-1:0] scaled_rate(longint sum);
         logic signed [127:0] prod;
         logic signed [127:0] q;
         prod = sum;
         prod = prod * $signed({96'b0, scale});
         q = (prod + (128'sd1 <<< (SAMPLE_W - 11))) >>> (SAMPLE_W - 10);
         if (q > RATE_HI)
            return RATE_HI[RATE_W-1:0];
         if (q < RATE_LO)
            return RATE_LO[RATE_W-1:0];
         return q[RATE_W-1:0];
      endfunction

      function void owe(longint sum, logic last, logic shrt);
         rate_item_type r;
         r.rate = shrt ? '0 : scaled_rate(sum);
         r.last_result = last;
         r.short_row = shrt;
         owed_rates.push_back(r);
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw, logic last);
         longint c;
         int unsigned n;
         c = $signed(raw);
         n = (count < 7) ? count + 1 : 7;
         if (mode == MODE_THREE_POINT) begin
            if (last && n < 2) begin
               owe(0, 1'b1, 1'b1);
            end else begin
               if (n == 2)
                  owe(-3 * win[0] + c, 1'b0, 1'b0);
               else if (n >= 3)
                  owe(win[1] - 2 * win[0] + c, 1'b0, 1'b0);
               if (last)
                  owe(win[0] - 3 * c, 1'b1, 1'b0);
            end
         end else begin
            if (last && n < 4) begin
               owe(0, 1'b1, 1'b1);
            end else begin
               if (n == 3)
                  owe(-46 * win[1] + 17 * win[0] - c, 1'b0, 1'b0);
               else if (n == 4)
                  owe(17 * win[2] - 30 * win[1] + 16 * win[0] - c, 1'b0, 1'b0);
               else if (n >= 5)
                  owe(-win[3] + 16 * win[2] - 30 * win[1] + 16 * win[0] - c, 1'b0, 1'b0);
               if (last) begin
                  owe(-win[2] + 16 * win[1] - 30 * win[0] + 17 * c, 1'b0, 1'b0);
                  owe(-win[1] + 17 * win[0] - 46 * c, 1'b1, 1'b0);
               end
            end
         end
         // a row end clears the window, otherwise shift the new sample in
         if (last) begin
            foreach (win[i]) win[i] = 0;
            count = 0;
         end else begin
            win[3] = win[2];
            win[2] = win[1];
            win[1] = win[0];
            win[0] = c;
            count = n;
         end
      endfunction

      function void check_result(logic [RATE_W-1:0] rate, logic last, logic shrt);
         rate_item_type e;
         if (owed_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: rate %0d last %0b short %0b",
                        $signed(rate), last, shrt);
            return;
         end
         e = owed_rates.pop_front();
         if (e.rate !== rate || e.last_result !== last || e.short_row !== shrt) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"result mismatch: rate %0d last %0b short %0b, ",
                         "got rate %0d last %0b short %0b"},
                        e.rate, e.last_result, e.short_row, $signed(rate), last, shrt);
         end
      endfunction

      function int pending();
         return owed_rates.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;  // sample
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RATE_W-1:0] rsp_tdata;  // rate
   logic rsp_tlast;
   logic rsp_tuser;  // short_row
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SCALE_W-1:0] csr_data = '0;

   // when set, neither side inserts idle cycles
   logic calm = 1'b0;
   int unsigned cycles = 0;
   stencil_board board;

   laplacian_stencil_stream i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure, changed at the falling edge
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // result monitor and run limit, sampled at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // entered and left at a falling edge; tvalid stays high on return
   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic last);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_sample(s, last);
      @(negedge clock);
   endtask

   // entered and left at a falling edge; csr_valid stays high on return
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [SCALE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, data);
      @(negedge clock);
   endtask

   // stop sending, then wait out every owed result plus the pipeline depth
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mode write with random upper bits, which the block must ignore
   task automatic write_mode(input logic m);
      write_register(REG_STENCIL_MODE, ($urandom() & ~32'd1) | {31'd0, m});
   endtask

   // rows of random length and content; the budget may cut the final row open
   task automatic random_rows(input int items);
      int left;
      int len;
      int k;
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] prev;
      left = items;
      prev = '0;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(14, 8) : $urandom_range(7, 1);
         for (k = 0; k < len && left > 0; k++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: s = $urandom();
               4, 5: s = $urandom_range(2000) - 1000;
               6: begin
                  case ($urandom_range(3))
                     0: s = SAMPLE_MAX;
                     1: s = SAMPLE_MIN;
                     2: s = '0;
                     default: s = '1;
                  endcase
               end
               default: s = prev + $urandom_range(1 << 20) - (1 << 19);
            endcase
            prev = s;
            send_sample(s, k == len - 1);
            left--;
         end
      end
   endtask

   initial begin
      logic [SCALE_W-1:0] scale;
      int p;
      board = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // three-point at reset settings: short row, two-sample row at the extremes, three
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(32'hffff_ffff, 1'b1);
      drain();

      // five-point: a row one short of the minimum, then a row of exactly four
      write_mode(MODE_FIVE_POINT);
      drain();
      send_sample(32'd1000, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(32'h4000_0000, 1'b0);
      send_sample(32'hc000_0000, 1'b1);
      // open a row in five-point mode, then finish it in three-point mode
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'h8765_4321, 1'b0);
      send_sample(32'h0fed_cba9, 1'b0);
      drain();
      write_mode(MODE_THREE_POINT);
      write_register(REG_SPARE_LO, $urandom());
      write_register(REG_SPARE_HI, $urandom());
      drain();
      send_sample(32'h7654_3210, 1'b0);
      send_sample(32'hf000_000f, 1'b1);
      drain();

      // largest scale with alternating extremes drives the rate into saturation
      write_mode(MODE_FIVE_POINT);
      write_register(REG_GRID_SCALE, SCALE_MAX);
      drain();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);
      drain();

      // random phases, each under its own mode and scale
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: scale = '0;
            1: scale = SCALE_MAX;
            2: scale = 32'd1;
            3: scale = SCALE_RESET;
            default: scale = $urandom_range(1) ? $urandom() : $urandom_range(4095);
         endcase
         write_mode(p[0]);
         write_register(REG_GRID_SCALE, scale);
         if ($urandom_range(2) == 0)
            write_register($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
         drain();
         // one whole phase with no idle cycles on either side
         calm = (p == 3);
         random_rows(PHASE_ITEMS);
         drain();
         calm = 1'b0;
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
